// ----- hdl/interval_occupancy_sweep_assert.svh -----
// Assertion macros for the occupancy sweep block.
// Each takes a label, an antecedent, a consequent and runs on clock/reset.
`ifndef INTERVAL_OCCUPANCY_SWEEP_ASSERT_SVH
`define INTERVAL_OCCUPANCY_SWEEP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IOS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("occupancy sweep check failed");
`define IOS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("occupancy sweep check failed");
`else
`define IOS_ASSERT_NOW(label, ante, cons)
`define IOS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/ios_pkg.sv -----
package ios_pkg;

   localparam int SEC_W  = 31;
   localparam int PART_W = 16;
   localparam int DIR_W  = 2;
   localparam int TIME_W = 63;
   localparam int CNT_W  = 6;

   localparam logic             FUNC_EOS = 1'b1;
   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_UNSORTED    = 2'd1,
      ST_QUEUE_FAULT = 2'd2,
      ST_OVERFLOW    = 2'd3
   } status_type;

   typedef struct packed {
      logic              func;
      logic              unit_defined;
      logic [SEC_W-1:0]  section_id;
      logic [PART_W-1:0] part_no;
      logic [DIR_W-1:0]  direction;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
   } req_type;

   typedef struct packed {
      logic              seg_valid;
      logic [SEC_W-1:0]  out_section;
      logic [PART_W-1:0] out_part;
      logic [DIR_W-1:0]  out_direction;
      logic [TIME_W-1:0] seg_start;
      logic [TIME_W-1:0] seg_end;
      logic [CNT_W-1:0]  car_count;
      logic              group_end;
      status_type        status;
      logic              last;
   } rsp_type;

   // Classified command between front and back
   typedef struct packed {
      logic              eos;
      logic [SEC_W-1:0]  section;
      logic [PART_W-1:0] part;
      logic [DIR_W-1:0]  dir;
      logic [TIME_W-1:0] s;
      logic [TIME_W-1:0] e;
   } cmd_type;

   typedef enum logic [2:0] {
      HOP_NONE,
      HOP_PUSH,
      HOP_POP,
      HOP_CLEAR,
      HOP_LOAD
   } heap_op_type;

   typedef struct packed {
      heap_op_type       op;
      logic [TIME_W-1:0] value;
   } heap_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DRAIN,
      S_LT,
      S_EQ,
      S_FIN,
      S_FLUSH
   } back_state_type;

endpackage

// ----- hdl/ios_front.sv -----
module ios_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ios_pkg::req_type req_data,
   output logic             q_valid,
   output ios_pkg::cmd_type q_head,
   input  logic             q_pop
);
   import ios_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       skip;
   logic       push;
   cmd_type    cmd_new;

   // Classify: skipped units never reach the back end
   always_comb begin
      skip = (req_data.func != FUNC_EOS) &&
             (!req_data.unit_defined || req_data.direction == DIR_NONE);
      cmd_new.eos     = (req_data.func == FUNC_EOS);
      cmd_new.section = req_data.section_id;
      cmd_new.part    = req_data.part_no;
      cmd_new.dir     = req_data.direction;
      cmd_new.s       = req_data.start_time;
      // end before start is taken as the start
      cmd_new.e       = (req_data.end_time < req_data.start_time) ?
                        req_data.start_time : req_data.end_time;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall && !skip;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_head    = q_ff[rd_ptr_ff];

   // Two-entry command queue
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ----- hdl/ios_heap.sv -----
module ios_heap #(
   parameter int HEAP_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ios_pkg::heap_cmd_type               hcmd,
   output logic [ios_pkg::TIME_W-1:0]          min_value,
   output logic [$clog2(HEAP_DEPTH+1)-1:0]     heap_size
);
   import ios_pkg::*;

   localparam int SIZE_W = $clog2(HEAP_DEPTH+1);

   // Sorted line of end times, smallest at index 0
   logic [TIME_W-1:0] ent_ff    [HEAP_DEPTH];
   logic [TIME_W-1:0] prev_val  [HEAP_DEPTH];
   logic [TIME_W-1:0] next_val  [HEAP_DEPTH];
   logic              prev_keep [HEAP_DEPTH];
   logic              keep      [HEAP_DEPTH];
   logic [SIZE_W-1:0] size_ff, size_in;

   // Each live entry not above the new value stays in place
   always_comb begin
      for (int i = 0; i < HEAP_DEPTH; i++) begin
         keep[i] = (SIZE_W'(i) < size_ff) && (ent_ff[i] <= hcmd.value);
      end
   end

   for (genvar g = 0; g < HEAP_DEPTH; g++) begin : g_nbr
      if (g == 0) begin : g_first
         assign prev_keep[g] = 1'b1;
         assign prev_val[g]  = '0;
      end else begin : g_rest
         assign prev_keep[g] = keep[g-1];
         assign prev_val[g]  = ent_ff[g-1];
      end
      if (g == HEAP_DEPTH-1) begin : g_last
         assign next_val[g] = '0;
      end else begin : g_inner
         assign next_val[g] = ent_ff[g+1];
      end
   end

   // Insert shifts the tail up, removal shifts everything down
   always_ff @(posedge clock) begin
      for (int i = 0; i < HEAP_DEPTH; i++) begin
         unique case (hcmd.op)
            HOP_PUSH: begin
               if (!keep[i]) begin
                  ent_ff[i] <= prev_keep[i] ? hcmd.value : prev_val[i];
               end
            end
            HOP_POP:  ent_ff[i] <= next_val[i];
            HOP_LOAD: begin
               if (i == 0) begin
                  ent_ff[i] <= hcmd.value;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (hcmd.op)
         HOP_PUSH:  size_in = size_ff + SIZE_W'(1);
         HOP_POP:   size_in = size_ff - SIZE_W'(1);
         HOP_CLEAR: size_in = '0;
         HOP_LOAD:  size_in = SIZE_W'(1);
         default:   size_in = size_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else begin
         size_ff <= size_in;
      end
   end

   assign min_value = ent_ff[0];
   assign heap_size = size_ff;

endmodule

// ----- hdl/ios_back.sv -----
`include "interval_occupancy_sweep_assert.svh"

module ios_back #(
   parameter int HEAP_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  ios_pkg::cmd_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ios_pkg::rsp_type rsp_data
);
   import ios_pkg::*;

   localparam int SIZE_W = $clog2(HEAP_DEPTH+1);

   back_state_type    state_ff, state_in;
   heap_cmd_type      hcmd;
   logic [TIME_W-1:0] heap_min;
   logic [SIZE_W-1:0] heap_size;

   logic [SEC_W-1:0]  cur_section_ff, cur_section_in;
   logic [PART_W-1:0] cur_part_ff, cur_part_in;
   logic [DIR_W-1:0]  cur_dir_ff, cur_dir_in;
   logic [TIME_W-1:0] open_ff, open_in;
   logic [SIZE_W-1:0] live_ff, live_in;
   logic [SIZE_W-1:0] k_ff, k_in;
   logic              first_pending_ff, first_pending_in;
   logic              halted_ff, halted_in;
   logic              hold_valid_ff, hold_valid_in;
   rsp_type           hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              out_load;
   rsp_type           out_data;

   logic              can_emit, hold_free, key_diff, heap_full, heap_empty;
   logic              seg_needed, step_ok, more_lt, more_eq;
   logic [SIZE_W:0]   live_plus;
   logic [SIZE_W-1:0] newcnt;
   logic              fin_emit;

   function automatic rsp_type make_rsp(
      input logic              valid,
      input logic [SEC_W-1:0]  sec,
      input logic [PART_W-1:0] part,
      input logic [DIR_W-1:0]  dir,
      input logic [TIME_W-1:0] s0,
      input logic [TIME_W-1:0] e0,
      input logic [CNT_W-1:0]  cnt,
      input logic              gend,
      input status_type        st,
      input logic              lst
   );
      rsp_type r;
      r.seg_valid     = valid;
      r.out_section   = sec;
      r.out_part      = part;
      r.out_direction = dir;
      r.seg_start     = s0;
      r.seg_end       = e0;
      r.car_count     = cnt;
      r.group_end     = gend;
      r.status        = st;
      r.last          = lst;
      return r;
   endfunction

   ios_heap #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_heap (
      .clock     (clock),
      .reset     (reset),
      .hcmd      (hcmd),
      .min_value (heap_min),
      .heap_size (heap_size)
   );

   // Shared conditions
   always_comb begin
      can_emit   = !rsp_valid_ff || !rsp_stall;
      hold_free  = !hold_valid_ff || can_emit;
      key_diff   = (q_head.section != cur_section_ff) || (q_head.part != cur_part_ff) ||
                   (q_head.dir != cur_dir_ff);
      heap_full  = (heap_size >= SIZE_W'(HEAP_DEPTH));
      heap_empty = (heap_size == '0);
      seg_needed = (heap_min != open_ff);
      step_ok    = !seg_needed || hold_free;
      more_lt    = !heap_empty && (heap_min < q_head.s);
      more_eq    = !heap_empty && (heap_min == q_head.s);
      live_plus  = {1'b0, live_ff} + (SIZE_W+1)'(1);
      newcnt     = (live_plus >= {1'b0, k_ff}) ? SIZE_W'(live_plus - {1'b0, k_ff}) : '0;
      fin_emit   = (newcnt != live_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_head.eos) begin
                  if (!halted_ff && !first_pending_ff) state_in = S_DRAIN;
               end else if (!halted_ff && !first_pending_ff) begin
                  if (key_diff) begin
                     state_in = S_DRAIN;
                  end else if (!heap_full && q_head.s > open_ff) begin
                     state_in = S_LT;
                  end
               end
            end
         end
         S_DRAIN: if (heap_empty && can_emit) state_in = S_IDLE;
         S_LT:    if (!more_lt) state_in = S_EQ;
         S_EQ:    if (!more_eq) state_in = S_FIN;
         S_FIN:   if (!fin_emit || hold_free) state_in = S_FLUSH;
         S_FLUSH: if (!hold_valid_ff || can_emit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      cur_section_in   = cur_section_ff;
      cur_part_in      = cur_part_ff;
      cur_dir_in       = cur_dir_ff;
      open_in          = open_ff;
      live_in          = live_ff;
      k_in             = k_ff;
      first_pending_in = first_pending_ff;
      halted_in        = halted_ff;
      hold_valid_in    = hold_valid_ff;
      hold_in          = hold_ff;
      out_load         = 1'b0;
      out_data         = hold_ff;
      q_pop            = 1'b0;
      hcmd.op          = HOP_NONE;
      hcmd.value       = q_head.e;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_head.eos) begin
                  if (halted_ff || first_pending_ff) begin
                     halted_in        = 1'b0;
                     first_pending_in = 1'b1;
                     live_in          = '0;
                     hcmd.op          = HOP_CLEAR;
                     q_pop            = 1'b1;
                  end
               end else if (halted_ff) begin
                  q_pop = 1'b1;
               end else if (first_pending_ff) begin
                  // open the first group
                  cur_section_in   = q_head.section;
                  cur_part_in      = q_head.part;
                  cur_dir_in       = q_head.dir;
                  open_in          = q_head.s;
                  live_in          = SIZE_W'(1);
                  first_pending_in = 1'b0;
                  hcmd.op          = HOP_LOAD;
                  q_pop            = 1'b1;
               end else if (key_diff) begin
                  // drain first
               end else if (heap_full) begin
                  if (can_emit) begin
                     out_load = 1'b1;
                     out_data = make_rsp(1'b0, cur_section_ff, cur_part_ff, cur_dir_ff,
                                         '0, '0, '0, 1'b0, ST_OVERFLOW, 1'b1);
                     q_pop    = 1'b1;
                  end
               end else if (q_head.s < open_ff) begin
                  if (can_emit) begin
                     out_load  = 1'b1;
                     out_data  = make_rsp(1'b0, cur_section_ff, cur_part_ff, cur_dir_ff,
                                          '0, '0, '0, 1'b1, ST_UNSORTED, 1'b1);
                     halted_in = 1'b1;
                     q_pop     = 1'b1;
                  end
               end else if (q_head.s == open_ff) begin
                  hcmd.op = HOP_PUSH;
                  live_in = live_ff + SIZE_W'(1);
                  q_pop   = 1'b1;
               end else begin
                  hcmd.op = HOP_PUSH;
                  k_in    = '0;
               end
            end
         end

         S_DRAIN, S_LT: begin
            if ((state_ff == S_DRAIN) ? !heap_empty : more_lt) begin
               // one end closes per cycle, unless a new segment must wait for the hold slot
               if (step_ok) begin
                  if (seg_needed) begin
                     out_load      = hold_valid_ff;
                     hold_in       = make_rsp(1'b1, cur_section_ff, cur_part_ff, cur_dir_ff,
                                              open_ff, heap_min, CNT_W'(live_ff), 1'b0,
                                              ST_OK, 1'b0);
                     hold_valid_in = 1'b1;
                     open_in       = heap_min;
                  end
                  hcmd.op = HOP_POP;
                  if (live_ff != '0) live_in = live_ff - SIZE_W'(1);
               end
            end else if (state_ff == S_DRAIN && can_emit) begin
               // close the group
               out_load = 1'b1;
               if (hold_valid_ff) begin
                  out_data           = hold_ff;
                  out_data.group_end = 1'b1;
                  out_data.last      = 1'b1;
               end else begin
                  out_data = make_rsp(1'b0, cur_section_ff, cur_part_ff, cur_dir_ff,
                                      '0, '0, '0, 1'b1, ST_OK, 1'b1);
               end
               hold_valid_in = 1'b0;
               q_pop         = 1'b1;
               if (q_head.eos) begin
                  halted_in        = 1'b0;
                  first_pending_in = 1'b1;
                  live_in          = '0;
                  hcmd.op          = HOP_CLEAR;
               end else begin
                  cur_section_in   = q_head.section;
                  cur_part_in      = q_head.part;
                  cur_dir_in       = q_head.dir;
                  open_in          = q_head.s;
                  live_in          = SIZE_W'(1);
                  first_pending_in = 1'b0;
                  hcmd.op          = HOP_LOAD;
               end
            end
         end

         S_EQ: begin
            // ends equal to the new start are exchanged
            if (more_eq) begin
               hcmd.op = HOP_POP;
               k_in    = k_ff + SIZE_W'(1);
            end
         end

         S_FIN: begin
            if (!fin_emit) begin
               live_in = newcnt;
            end else if (hold_free) begin
               out_load      = hold_valid_ff;
               hold_in       = make_rsp(1'b1, cur_section_ff, cur_part_ff, cur_dir_ff,
                                        open_ff, q_head.s, CNT_W'(live_ff), 1'b0,
                                        ST_OK, 1'b0);
               hold_valid_in = 1'b1;
               open_in       = q_head.s;
               live_in       = newcnt;
            end
         end

         S_FLUSH: begin
            if (!hold_valid_ff) begin
               q_pop = 1'b1;
            end else if (can_emit) begin
               out_load      = 1'b1;
               out_data      = hold_ff;
               out_data.last = 1'b1;
               hold_valid_in = 1'b0;
               q_pop         = 1'b1;
            end
         end

         default: ;
      endcase
   end

   // Output register
   always_comb begin
      rsp_in       = out_load ? out_data : rsp_ff;
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         cur_section_ff   <= '0;
         cur_part_ff      <= '0;
         cur_dir_ff       <= DIR_NONE;
         open_ff          <= '0;
         live_ff          <= '0;
         k_ff             <= '0;
         first_pending_ff <= 1'b1;
         halted_ff        <= 1'b0;
         hold_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cur_section_ff   <= cur_section_in;
         cur_part_ff      <= cur_part_in;
         cur_dir_ff       <= cur_dir_in;
         open_ff          <= open_in;
         live_ff          <= live_in;
         k_ff             <= k_in;
         first_pending_ff <= first_pending_in;
         halted_ff        <= halted_in;
         hold_valid_ff    <= hold_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `IOS_ASSERT_NOW(a_no_push_full, hcmd.op == HOP_PUSH, heap_size < SIZE_W'(HEAP_DEPTH))
   `IOS_ASSERT_NOW(a_idle_no_hold, state_ff == S_IDLE, !hold_valid_ff)
   `IOS_ASSERT_NOW(a_halt_in_group, halted_ff, !first_pending_ff)
   `IOS_ASSERT_NOW(a_load_room, out_load, can_emit)

endmodule

// ----- hdl/interval_occupancy_sweep.sv -----
// Timing: with the back end free, a marker goes from the queue head straight to the output
// register and a segment passes the hold register first; a popped end closing no segment
// delays it further. A unit that opens the group or shares the open start is taken at once;
// others wait while ends are closed and exchanged one at a time, and a drain pops every
// stored end. The pop loop over the sorted end-time line sets the rate; the 2-entry queue
// hides front-end accepts. Reset is synchronous, active high, and empties queue and store.
module interval_occupancy_sweep #(
   parameter int HEAP_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ios_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ios_pkg::rsp_type rsp_data
);
   import ios_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_head;

   ios_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   ios_back #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- dv/ios_checker.sv -----
// Watches both channels of the occupancy sweep, predicts the segment stream
// for every accepted request and compares each accepted response in order.
module ios_checker #(
   parameter int HEAP_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ios_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ios_pkg::rsp_type rsp_data,
   output int               errors,
   output int               pending
);
   import ios_pkg::*;

   // predictor state
   logic [TIME_W-1:0] end_times [HEAP_DEPTH];
   int                live_ends;
   logic [SEC_W-1:0]  grp_section;
   logic [PART_W-1:0] grp_part;
   logic [DIR_W-1:0]  grp_dir;
   logic [TIME_W-1:0] open_time;
   int                occupancy;
   bit                awaiting_first;
   bit                stopped;

   rsp_type segment_q [$];   // responses still owed by the block
   rsp_type item_q [$];      // responses of the request being predicted

   function automatic void clear_sweep();
      live_ends      = 0;
      grp_section    = '0;
      grp_part       = '0;
      grp_dir        = DIR_NONE;
      open_time      = '0;
      occupancy      = 0;
      awaiting_first = 1;
      stopped        = 0;
   endfunction

   function automatic void push_end(logic [TIME_W-1:0] v);
      int i;
      int p;
      if (live_ends >= HEAP_DEPTH) return;
      i = live_ends;
      live_ends++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (end_times[p] <= v) break;
         end_times[i] = end_times[p];
         i = p;
      end
      end_times[i] = v;
   endfunction

   function automatic logic [TIME_W-1:0] pop_end();
      logic [TIME_W-1:0] top;
      logic [TIME_W-1:0] v;
      int i;
      int n;
      int c;
      if (live_ends == 0) return '0;
      top = end_times[0];
      live_ends--;
      n = live_ends;
      if (n == 0) return top;
      v = end_times[n];
      i = 0;
      forever begin
         c = 2 * i + 1;
         if (c >= n) break;
         if (c + 1 < n && end_times[c+1] < end_times[c]) c++;
         if (end_times[c] >= v) break;
         end_times[i] = end_times[c];
         i = c;
      end
      end_times[i] = v;
      return top;
   endfunction

   function automatic void add_result(bit seg, logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                                      int cnt, bit gend, status_type st);
      rsp_type x;
      if (item_q.size() >= HEAP_DEPTH + 1) return;
      x.seg_valid     = seg;
      x.out_section   = grp_section;
      x.out_part      = grp_part;
      x.out_direction = grp_dir;
      x.seg_start     = s;
      x.seg_end       = e;
      x.car_count     = cnt[CNT_W-1:0];
      x.group_end     = gend;
      x.status        = st;
      x.last          = 0;
      item_q.push_back(x);
   endfunction

   // empty the end-time store, closing the group
   function automatic void close_group();
      int      first_idx;
      logic [TIME_W-1:0] e;
      rsp_type x;
      first_idx = item_q.size();
      while (live_ends > 0) begin
         e = pop_end();
         if (e != open_time) begin
            add_result(1, open_time, e, occupancy, 0, ST_OK);
            open_time = e;
         end
         if (occupancy > 0) occupancy--;
      end
      occupancy = 0;
      if (item_q.size() > first_idx) begin
         x = item_q[item_q.size()-1];
         x.group_end = 1;
         item_q[item_q.size()-1] = x;
      end else begin
         add_result(0, '0, '0, 0, 1, ST_OK);
      end
   endfunction

   function automatic void start_group(req_type r, logic [TIME_W-1:0] e);
      grp_section    = r.section_id;
      grp_part       = r.part_no;
      grp_dir        = r.direction;
      open_time      = r.start_time;
      live_ends      = 0;
      push_end(e);
      occupancy      = 1;
      awaiting_first = 0;
   endfunction

   function automatic void predict_sweep(req_type r);
      logic [TIME_W-1:0] s;
      logic [TIME_W-1:0] e;
      logic [TIME_W-1:0] t;
      int      k;
      int      next_occ;
      rsp_type x;
      item_q.delete();
      s = r.start_time;
      e = r.end_time;
      if (r.func == FUNC_EOS) begin
         if (!stopped && !awaiting_first) close_group();
         stopped        = 0;
         awaiting_first = 1;
         live_ends      = 0;
         occupancy      = 0;
      end else if (!stopped && r.unit_defined && r.direction != DIR_NONE) begin
         if (e < s) e = s;
         if (awaiting_first) begin
            start_group(r, e);
         end else if (r.section_id != grp_section || r.part_no != grp_part ||
                      r.direction != grp_dir) begin
            close_group();
            start_group(r, e);
         end else if (live_ends >= HEAP_DEPTH) begin
            add_result(0, '0, '0, 0, 0, ST_OVERFLOW);
         end else if (s < open_time) begin
            add_result(0, '0, '0, 0, 1, ST_UNSORTED);
            stopped = 1;
         end else if (s == open_time) begin
            push_end(e);
            occupancy++;
         end else begin
            k = 0;
            push_end(e);
            while (live_ends > 0 && end_times[0] < s) begin
               t = pop_end();
               if (t != open_time) begin
                  add_result(1, open_time, t, occupancy, 0, ST_OK);
                  open_time = t;
               end
               if (occupancy > 0) occupancy--;
            end
            // ends equal to the new start are exchanged
            while (live_ends > 0 && end_times[0] == s) begin
               t = pop_end();
               k++;
            end
            next_occ = (occupancy + 1 >= k) ? occupancy + 1 - k : 0;
            if (next_occ != occupancy) begin
               add_result(1, open_time, s, occupancy, 0, ST_OK);
               open_time = s;
            end
            occupancy = next_occ;
         end
      end
      foreach (item_q[i]) begin
         x = item_q[i];
         x.last = (i == item_q.size() - 1);
         segment_q.push_back(x);
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      errors++;
   endtask

   function automatic void clear_expected();
      segment_q.delete();
   endfunction

   // request transfers feed the predictor, response transfers are compared
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_sweep();
         clear_expected();
         errors = 0;
      end else begin
         if (req_valid && !req_stall) predict_sweep(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (segment_q.size() == 0) begin
               report_mismatch("response count", 64'd0, 64'd1);
            end else begin
               want = segment_q.pop_front();
               if (rsp_data.seg_valid != want.seg_valid)
                  report_mismatch("seg_valid", want.seg_valid, rsp_data.seg_valid);
               if (rsp_data.out_section != want.out_section)
                  report_mismatch("out_section", want.out_section, rsp_data.out_section);
               if (rsp_data.out_part != want.out_part)
                  report_mismatch("out_part", want.out_part, rsp_data.out_part);
               if (rsp_data.out_direction != want.out_direction)
                  report_mismatch("out_direction", want.out_direction,
                                  rsp_data.out_direction);
               if (rsp_data.seg_start != want.seg_start)
                  report_mismatch("seg_start", want.seg_start, rsp_data.seg_start);
               if (rsp_data.seg_end != want.seg_end)
                  report_mismatch("seg_end", want.seg_end, rsp_data.seg_end);
               if (rsp_data.car_count != want.car_count)
                  report_mismatch("car_count", want.car_count, rsp_data.car_count);
               if (rsp_data.group_end != want.group_end)
                  report_mismatch("group_end", want.group_end, rsp_data.group_end);
               if (rsp_data.status != want.status)
                  report_mismatch("status", want.status, rsp_data.status);
               if (rsp_data.last != want.last)
                  report_mismatch("last", want.last, rsp_data.last);
            end
         end
      end
      pending = segment_q.size();
   end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
   import ios_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int UNIT_TARGET = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      errors;
   int      pending;

   bit      calm;       // no idling on either side while set
   bit      hold_off;   // receiver backs up the block once
   int      quiet_cycles;
   int      units_sent;

   interval_occupancy_sweep dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   ios_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .errors    (errors),
      .pending   (pending)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // receiver: random stall, one long hold-off
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 0;
      rsp_stall = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off && !hold_done) begin
            hold_left = 400;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 28);
         end
         @(posedge clock);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic req_type make_unit(bit def, logic [SEC_W-1:0] sec,
                                         logic [PART_W-1:0] part, logic [DIR_W-1:0] dir,
                                         logic [TIME_W-1:0] s, logic [TIME_W-1:0] e);
      req_type r;
      r.func         = ~FUNC_EOS;
      r.unit_defined = def;
      r.section_id   = sec;
      r.part_no      = part;
      r.direction    = dir;
      r.start_time   = s;
      r.end_time     = e;
      return r;
   endfunction

   function automatic req_type make_eos();
      req_type r;
      r = make_unit(1'($urandom_range(0, 1)), SEC_W'($urandom), PART_W'($urandom),
                    DIR_W'($urandom), TIME_W'({$urandom, $urandom}),
                    TIME_W'({$urandom, $urandom}));
      r.func = FUNC_EOS;
      return r;
   endfunction

   task automatic send(req_type r);
      if (!calm && $urandom_range(0, 99) < 28) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      units_sent++;
   endtask

   // one group of sorted units with random content, now and then broken
   task automatic send_group();
      logic [SEC_W-1:0]  sec;
      logic [PART_W-1:0] part;
      logic [DIR_W-1:0]  dir;
      logic [TIME_W-1:0] s;
      logic [TIME_W-1:0] e;
      int n;
      bit pile;
      sec  = ($urandom_range(0, 3) == 0) ? SEC_W'($urandom_range(0, 1)) : SEC_W'($urandom);
      part = PART_W'($urandom);
      dir  = DIR_W'($urandom_range(1, 3));
      s    = TIME_W'({$urandom, $urandom});
      s[9:0] = '0;
      if (s[TIME_W-1:10] == '1) s = '0;
      pile = ($urandom_range(0, 11) == 0);
      n    = pile ? $urandom_range(33, 35) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         if (!pile) s += $urandom_range(0, 3);
         e = s + $urandom_range(0, 6);
         if ($urandom_range(0, 19) == 0) e = s - $urandom_range(0, 4);
         if ($urandom_range(0, 14) == 0)
            send(make_unit(1'($urandom_range(0, 1)), sec, part,
                           $urandom_range(0, 1) ? DIR_NONE : dir, s, e));
         if ($urandom_range(0, 39) == 0 && s > 0)
            send(make_unit(1'b1, sec, part, dir, s - 1, e));
         else
            send(make_unit(1'b1, sec, part, dir, s, e));
      end
      if ($urandom_range(0, 2) == 0) send(make_eos());
   endtask

   initial begin
      req_valid  = 0;
      req_data   = '0;
      reset      = 1;
      calm       = 0;
      hold_off   = 0;
      units_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: no group open, skips, first unit, exchange, unsorted, halt
      send(make_eos());
      send(make_unit(1'b0, 31'd5, 16'd1, 2'd1, 63'd10, 63'd20));
      send(make_unit(1'b1, 31'd5, 16'd1, DIR_NONE, 63'd10, 63'd20));
      send(make_unit(1'b1, 31'd5, 16'd1, 2'd1, 63'd10, 63'd20));
      send(make_unit(1'b1, 31'd5, 16'd1, 2'd1, 63'd10, 63'd15));
      send(make_unit(1'b1, 31'd5, 16'd1, 2'd1, 63'd15, 63'd30));
      send(make_unit(1'b1, 31'd5, 16'd1, 2'd1, 63'd20, 63'd25));
      send(make_unit(1'b1, 31'd5, 16'd1, 2'd1, 63'd40, 63'd35));
      send(make_unit(1'b1, 31'd5, 16'd1, 2'd1, 63'd41, 63'd41));
      send(make_unit(1'b1, 31'd5, 16'd2, 2'd1, 63'd41, 63'd60));
      send(make_unit(1'b1, 31'd5, 16'd2, 2'd1, 63'd41, 63'd60));
      send(make_unit(1'b1, 31'd5, 16'd2, 2'd1, 63'd60, 63'd70));
      send(make_unit(1'b1, 31'd5, 16'd2, 2'd1, 63'd50, 63'd70));
      send(make_unit(1'b1, 31'd5, 16'd2, 2'd1, 63'd90, 63'd95));
      send(make_eos());
      send(make_unit(1'b1, '1, '1, 2'd3, '1, '1));
      send(make_unit(1'b1, '1, '1, 2'd2, '1, '0));
      send(make_unit(1'b1, '0, '0, 2'd2, '0, '1));
      send(make_unit(1'b1, '0, '0, 2'd2, '0, 63'd5));
      send(make_unit(1'b1, '0, '0, 2'd2, 63'd5, 63'd5));
      send(make_eos());
      send(make_eos());

      // random groups; one calm stretch and one receiver hold-off
      while (units_sent < UNIT_TARGET) begin
         calm = (units_sent >= 100 && units_sent < 160);
         if (units_sent >= 200) hold_off = 1;
         send_group();
      end
      calm = 0;
      send(make_eos());
      req_valid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
